[rtl/psfr_pkg.sv]
// shared constants and types for the packet sequence frame reassembler
// no dependencies; imported by the reassembler and its checker

package psfr_pkg;

    localparam int MAX_PACKET = 64;
    localparam int MAX_FRAME  = 1024;

    localparam int POS_W   = $clog2(MAX_PACKET + 1);
    localparam int FLEN_W  = 11;
    localparam int ADDR_W  = $clog2(MAX_FRAME);
    localparam int BYTE_W  = 8;
    localparam int IDX_W   = 8;
    localparam int LOST_W  = 16;

    localparam int OUT_FIELDS_W = ADDR_W + BYTE_W + LOST_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [FLEN_W-1:0] FLEN_RESET = FLEN_W'(64);

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   addr;
        logic [BYTE_W-1:0]   data;
        logic                done;
        logic [LOST_W-1:0]   lost;
    } t_result;

endpackage

[rtl/packet_sequence_frame_reassembler.sv]
// packet sequence frame reassembler: rebuilds frames from usb packet bytes
// and issues frame buffer writes; depends on psfr_pkg
//
// usage:
//   slave stream: one packet byte per word, s_axis_tlast on the last byte of
//   each packet. master stream: one result word per input word, carrying the
//   frame buffer write (enable on m_axis_tuser, address and data in tdata),
//   the running loss count, and m_axis_tlast when a whole frame sits in the
//   buffer. frame length is set through i_cfg_we / i_cfg_wdata while idle,
//   a rule the user keeps and the block does not enforce; up to 64 selects
//   short mode (each packet is one frame). an accepted word passes the input
//   register, then the result register. throughput: one word per cycle when
//   not stalled, set by the single-pass update of packet and frame counters.
//   reset: synchronous, active low; clears all counters, the loss count and
//   both pipeline stages, and restores frame length 64.
//   stall: when the receiver holds m_axis_tready low the result register
//   keeps its word, the input register fills behind it, and then
//   s_axis_tready drops; nothing is lost or repeated.

module packet_sequence_frame_reassembler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [psfr_pkg::FLEN_W-1:0]        i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // in_byte
    input  logic                               s_axis_tlast,  // packet_end
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // write_address, write_data, lost_count, zero fill
    output logic [psfr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                               m_axis_tuser,  // write_enable
    output logic                               m_axis_tlast   // frame_done
);
    import psfr_pkg::*;

    logic [FLEN_W-1:0]  r_frame_length;

    logic               r_in_valid;
    logic [BYTE_W-1:0]  r_in_byte;
    logic               r_in_last;

    logic               r_out_valid;
    t_result            r_out;
    t_result            n_out;

    logic [POS_W-1:0]   r_pos,  n_pos;
    logic [FLEN_W-1:0]  r_fill, n_fill;
    logic [IDX_W-1:0]   r_exp,  n_exp;
    logic               r_skip, n_skip;
    logic [LOST_W-1:0]  r_lost, n_lost;

    logic               adv;
    logic [FLEN_W-1:0]  flen;
    logic               short_mode;
    logic [1:0]         loss_inc;

    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;

    assign flen       = (r_frame_length > FLEN_W'(MAX_FRAME)) ? FLEN_W'(MAX_FRAME)
                                                              : r_frame_length;
    assign short_mode = (flen <= FLEN_W'(MAX_PACKET));

    always_comb begin
        n_out      = '0;
        n_fill     = r_fill;
        n_exp      = r_exp;
        n_skip     = r_skip;
        loss_inc   = 2'd0;

        if (short_mode) begin
            if (FLEN_W'(r_pos) < flen) begin
                n_out.we   = 1'b1;
                n_out.addr = ADDR_W'(r_pos);
                n_out.data = r_in_byte;
            end
            if (r_in_last) begin
                if (FLEN_W'(r_pos) + FLEN_W'(1) == flen) begin
                    n_out.done = 1'b1;
                end else begin
                    loss_inc = 2'd1;
                end
            end
        end else if (!r_skip) begin
            if (r_pos == '0) begin
                // sequence index byte
                if (r_in_byte != r_exp) begin
                    if (r_fill != '0) begin
                        loss_inc = loss_inc + 2'd1;
                    end
                    n_fill = '0;
                    n_exp  = '0;
                    if (r_in_byte != '0) begin
                        loss_inc = loss_inc + 2'd1;
                        n_skip   = 1'b1;
                    end
                end
            end else begin
                if (r_pos == POS_W'(1)) begin
                    n_exp = r_exp + IDX_W'(1);
                end
                if (r_fill < flen) begin
                    n_out.we   = 1'b1;
                    n_out.addr = r_fill[ADDR_W-1:0];
                    n_out.data = r_in_byte;
                    n_fill     = r_fill + FLEN_W'(1);
                end
            end
            if (r_in_last && !n_skip && n_fill == flen) begin
                n_out.done = 1'b1;
                n_fill     = '0;
                n_exp      = '0;
            end
        end

        n_lost     = r_lost + LOST_W'(loss_inc);
        n_out.lost = n_lost;

        if (r_in_last) begin
            n_pos  = '0;
            n_skip = 1'b0;
        end else if (r_pos < POS_W'(MAX_PACKET)) begin
            n_pos = r_pos + POS_W'(1);
        end else begin
            n_pos = r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_length <= FLEN_RESET;
        end else if (i_cfg_we) begin
            r_frame_length <= i_cfg_wdata;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_fill      <= '0;
            r_exp       <= '0;
            r_skip      <= 1'b0;
            r_lost      <= '0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
            r_pos       <= n_pos;
            r_fill      <= n_fill;
            r_exp       <= n_exp;
            r_skip      <= n_skip;
            r_lost      <= n_lost;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.we;
    assign m_axis_tlast  = r_out.done;
    assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                            r_out.lost, r_out.data, r_out.addr};

endmodule

[rtl/psfr_checker.sv]
// port-level checker for the packet sequence frame reassembler
// depends on psfr_pkg; attached to the top level by the bind below

module psfr_port_assertions (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tready,
    input  logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic [psfr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               m_axis_tuser,
    input  logic                               m_axis_tlast
);
    import psfr_pkg::*;

    // a held result keeps its word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // no write means address and data read as zero
    a_idle_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[ADDR_W+BYTE_W-1:0] == '0)
        else $error("address or data set without write enable");

    // input stalls only behind a held result
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with the result side free");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind packet_sequence_frame_reassembler psfr_port_assertions u_psfr_port_assertions (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .s_axis_tready  (s_axis_tready),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .m_axis_tuser   (m_axis_tuser),
    .m_axis_tlast   (m_axis_tlast)
);
